/* design/clock_ring_display_frame_encoder_assert.svh */
// assertion macros for the frame encoder
`ifndef CLOCK_RING_DISPLAY_FRAME_ENCODER_ASSERT_SVH
`define CLOCK_RING_DISPLAY_FRAME_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS
`define CRDFE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("%m: property failed");
`define CRDFE_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define CRDFE_ASSERT(lbl, clk, rstn, prop)
`define CRDFE_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

/* design/crdfe_pkg.sv */
package crdfe_pkg;

    localparam int unsigned RING_DOTS   = 60;
    localparam int unsigned FRAMES      = 5;
    localparam int unsigned IMAGE_BYTES = 20;

    typedef enum logic [1:0] {
        ACT_TIME = 2'd0,
        ACT_CW   = 2'd1,
        ACT_CCW  = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    localparam logic REG_RING_BRIGHTNESS  = 1'b0;
    localparam logic REG_DIGIT_BRIGHTNESS = 1'b1;

    localparam logic [7:0] SEG_COLON = 8'h80;
    localparam logic [7:0] SEG_ZERO  = 8'h3F;

    localparam logic BUS_RING  = 1'b0;
    localparam logic BUS_DIGIT = 1'b1;

    typedef struct packed {
        logic [5:0] dot_first;
        logic [5:0] dot_last;
        logic [7:0] seg_sec_tens;
        logic [7:0] seg_sec_ones;
        logic [7:0] seg_hour_tens;
        logic [7:0] seg_hour_ones;
        logic [7:0] seg_min_tens;
        logic [7:0] seg_min_ones;
    } t_job;

    typedef struct packed {
        logic [3:0] ring;
        logic [3:0] digit;
    } t_cfg;

    function automatic logic [2:0] f_tens(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd60) t = 3'd6;
        else if (v >= 6'd50) t = 3'd5;
        else if (v >= 6'd40) t = 3'd4;
        else if (v >= 6'd30) t = 3'd3;
        else if (v >= 6'd20) t = 3'd2;
        else if (v >= 6'd10) t = 3'd1;
        else t = 3'd0;
        return t;
    endfunction

    function automatic logic [3:0] f_ones(input logic [5:0] v);
        logic [6:0] prod;
        logic [5:0] rem;
        prod = 7'(f_tens(v)) * 7'd10;
        rem  = v - prod[5:0];
        return rem[3:0];
    endfunction

    function automatic logic [7:0] f_seg(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic f_frame_bus(input logic [2:0] k);
        logic b;
        unique case (k)
            3'd3, 3'd4: b = BUS_DIGIT;
            default:    b = BUS_RING;
        endcase
        return b;
    endfunction

    function automatic logic [6:0] f_frame_addr(input logic [2:0] k);
        logic [6:0] a;
        unique case (k)
            3'd0:    a = 7'h38;
            3'd1:    a = 7'h3A;
            3'd2:    a = 7'h3B;
            3'd3:    a = 7'h39;
            3'd4:    a = 7'h3A;
            default: a = 7'h38;
        endcase
        return a;
    endfunction

    function automatic logic [7:0] f_control(input logic [3:0] b);
        logic [2:0] s;
        s = b[3] ? 3'd7 : b[2:0];
        return {1'b0, s, 4'h7};
    endfunction

    // bit position of a ring dot in the raw image
    function automatic logic [7:0] f_dot_pos(input logic [5:0] d);
        logic [7:0] p;
        if (d == 6'd0) p = 8'd27;
        else if (d <= 6'd32) p = 8'd63 + 8'(d);
        else if (d <= 6'd56) p = 8'(d) - 8'd33;
        else p = 8'(d) - 8'd33;
        return p;
    endfunction

endpackage

/* design/crdfe_front.sv */
module crdfe_front (
    input  logic                i_in_valid,
    input  logic                i_q_ready,
    input  logic [1:0]          i_action,
    input  logic [4:0]          i_hour,
    input  logic [5:0]          i_minute,
    input  logic [5:0]          i_second,
    input  logic                i_half_step,
    input  logic [5:0]          i_ring_count,
    output logic                o_push,
    output crdfe_pkg::t_job     o_job
);

    crdfe_pkg::t_action act;
    logic [5:0]         count_sat;
    logic [5:0]         hour_ext;

    assign act       = crdfe_pkg::t_action'(i_action);
    assign count_sat = (i_ring_count > 6'(crdfe_pkg::RING_DOTS)) ?
                       6'(crdfe_pkg::RING_DOTS) : i_ring_count;
    assign hour_ext  = {1'b0, i_hour};
    assign o_push    = i_in_valid && i_q_ready && (act != crdfe_pkg::ACT_NONE);

    always_comb begin
        o_job.dot_first     = '0;
        o_job.dot_last      = count_sat;
        o_job.seg_sec_tens  = crdfe_pkg::SEG_ZERO;
        o_job.seg_sec_ones  = crdfe_pkg::SEG_ZERO;
        o_job.seg_hour_tens = crdfe_pkg::SEG_ZERO;
        o_job.seg_hour_ones = crdfe_pkg::SEG_ZERO;
        o_job.seg_min_tens  = crdfe_pkg::SEG_ZERO;
        o_job.seg_min_ones  = crdfe_pkg::SEG_ZERO;
        unique case (act)
            crdfe_pkg::ACT_TIME: begin
                o_job.dot_last = (i_second >= 6'(crdfe_pkg::RING_DOTS - 1)) ?
                                 6'(crdfe_pkg::RING_DOTS) : i_second + 6'd1;
                o_job.seg_sec_tens  = crdfe_pkg::f_seg({1'b0, crdfe_pkg::f_tens(i_second)});
                o_job.seg_sec_ones  = crdfe_pkg::f_seg(crdfe_pkg::f_ones(i_second));
                o_job.seg_hour_tens = crdfe_pkg::f_seg({1'b0, crdfe_pkg::f_tens(hour_ext)})
                                      | (i_half_step ? 8'h00 : crdfe_pkg::SEG_COLON);
                o_job.seg_hour_ones = crdfe_pkg::f_seg(crdfe_pkg::f_ones(hour_ext));
                o_job.seg_min_tens  = crdfe_pkg::f_seg({1'b0, crdfe_pkg::f_tens(i_minute)});
                o_job.seg_min_ones  = crdfe_pkg::f_seg(crdfe_pkg::f_ones(i_minute));
            end
            crdfe_pkg::ACT_CW: begin
                o_job.dot_last = count_sat;
            end
            crdfe_pkg::ACT_CCW: begin
                o_job.dot_first = 6'(crdfe_pkg::RING_DOTS) - count_sat;
                o_job.dot_last  = 6'(crdfe_pkg::RING_DOTS);
            end
            crdfe_pkg::ACT_NONE: begin
                o_job.dot_last = '0;
            end
            default: begin
                o_job.dot_last = '0;
            end
        endcase
    end

endmodule

/* design/crdfe_queue.sv */
module crdfe_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  crdfe_pkg::t_job  i_job,
    output logic             o_ready,
    output logic             o_valid,
    output crdfe_pkg::t_job  o_job,
    input  logic             i_pop
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    crdfe_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr;
    logic [PW-1:0]   n_rd;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign n_wr    = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* design/crdfe_back.sv */
`include "clock_ring_display_frame_encoder_assert.svh"

module crdfe_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  crdfe_pkg::t_job  i_q_job,
    output logic             o_q_pop,
    input  crdfe_pkg::t_cfg  i_cfg,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_bus_select,
    output logic [6:0]       o_device_address,
    output logic [7:0]       o_control_byte,
    output logic [7:0]       o_data_byte0,
    output logic [7:0]       o_data_byte1,
    output logic [7:0]       o_data_byte2,
    output logic [7:0]       o_data_byte3,
    output logic             o_last_frame
);

    localparam int unsigned IW = crdfe_pkg::IMAGE_BYTES * 8;

    crdfe_pkg::t_job r_job;
    logic            r_busy;
    logic [2:0]      r_frame;
    logic            r_out_valid;
    logic [IW-1:0]   image;
    logic            can_load;
    logic            emit;
    logic            last;
    logic            bus;

    // raw display image of the held job
    always_comb begin
        image = '0;
        for (int d = 0; d < crdfe_pkg::RING_DOTS; d++) begin
            if ((6'(d) >= r_job.dot_first) && (6'(d) < r_job.dot_last)) begin
                image[crdfe_pkg::f_dot_pos(6'(d))] = 1'b1;
            end
        end
        image[12*8 +: 8] = r_job.seg_sec_tens;
        image[13*8 +: 8] = r_job.seg_sec_ones;
        image[16*8 +: 8] = r_job.seg_hour_tens;
        image[17*8 +: 8] = r_job.seg_hour_ones;
        image[18*8 +: 8] = r_job.seg_min_tens;
        image[19*8 +: 8] = r_job.seg_min_ones;
        // fixed hour and quarter dots
        image[3*8 +: 8] = image[3*8 +: 8] | 8'hF0;
        image[6*8 +: 8] = image[6*8 +: 8] | 8'h7F;
        image[7*8 +: 8] = image[7*8 +: 8] | 8'h1F;
    end

    assign can_load = !r_out_valid || i_out_ready;
    assign emit     = can_load && r_busy;
    assign last     = (r_frame == 3'(crdfe_pkg::FRAMES - 1));
    assign o_q_pop  = i_q_valid && (!r_busy || (emit && last));
    assign bus      = crdfe_pkg::f_frame_bus(r_frame);

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_frame     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (can_load) begin
                r_out_valid <= r_busy;
            end
            if (emit) begin
                r_frame <= last ? '0 : r_frame + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
            if (o_q_pop) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_job;
        end
        if (emit) begin
            o_bus_select     <= bus;
            o_device_address <= crdfe_pkg::f_frame_addr(r_frame);
            o_control_byte   <= crdfe_pkg::f_control(bus ? i_cfg.digit : i_cfg.ring);
            o_data_byte0     <= image[{r_frame, 2'd0, 3'b000} +: 8];
            o_data_byte1     <= image[{r_frame, 2'd1, 3'b000} +: 8];
            o_data_byte2     <= image[{r_frame, 2'd2, 3'b000} +: 8];
            o_data_byte3     <= image[{r_frame, 2'd3, 3'b000} +: 8];
            o_last_frame     <= last;
        end
    end

    `CRDFE_ASSERT(a_frames_run_on, i_clk, i_rst_n, (o_out_valid && i_out_ready && !o_last_frame) |=> o_out_valid)
    `CRDFE_ASSERT(a_last_on_digit_bus, i_clk, i_rst_n, (o_out_valid && o_last_frame) |-> (o_bus_select && (o_device_address == crdfe_pkg::f_frame_addr(3'(crdfe_pkg::FRAMES - 1)))))
    `CRDFE_ASSERT(a_stall_holds_frame, i_clk, i_rst_n, (r_busy && r_out_valid && !i_out_ready) |=> $stable(r_frame))
    `CRDFE_ASSERT_NEVER(a_frame_range, i_clk, i_rst_n, r_frame > 3'(crdfe_pkg::FRAMES - 1))

endmodule

/* design/clock_ring_display_frame_encoder.sv */
// clock face and loading ring display encoder
// input channel: i_in_valid / o_in_ready with action, hour, minute, second,
// half_step and ring_count; an action code of 3 is accepted and dropped
// output channel: o_out_valid / i_out_ready, one driver frame per transaction,
// five frames per item: three ring bus frames then two digit bus frames,
// o_last_frame marks the fifth
// config channel: i_cfg_valid / o_cfg_ready, always ready; index 0 ring
// brightness, index 1 digit brightness, both 7 after reset
// path: an item passes the job queue, the held job register, then the output
// register; throughput: one frame per cycle while i_out_ready holds, set by the
// output register that the frame sequencer fills once per cycle
// a small job queue sits between the input classifier and the sequencer, so
// the input keeps taking items while frames wait at a stalled receiver;
// when the queue is full o_in_ready drops
// reset (synchronous, active low) empties the queue, drops any frame in
// flight and restores both brightness registers
module clock_ring_display_frame_encoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  logic [4:0] i_hour,
    input  logic [5:0] i_minute,
    input  logic [5:0] i_second,
    input  logic       i_half_step,
    input  logic [5:0] i_ring_count,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_bus_select,
    output logic [6:0] o_device_address,
    output logic [7:0] o_control_byte,
    output logic [7:0] o_data_byte0,
    output logic [7:0] o_data_byte1,
    output logic [7:0] o_data_byte2,
    output logic [7:0] o_data_byte3,
    output logic       o_last_frame,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [3:0] i_cfg_data
);

    crdfe_pkg::t_cfg r_cfg;
    crdfe_pkg::t_job push_job;
    crdfe_pkg::t_job q_job;
    logic            push;
    logic            q_ready;
    logic            q_valid;
    logic            q_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ring  <= 4'd7;
            r_cfg.digit <= 4'd7;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                crdfe_pkg::REG_RING_BRIGHTNESS:  r_cfg.ring  <= i_cfg_data;
                crdfe_pkg::REG_DIGIT_BRIGHTNESS: r_cfg.digit <= i_cfg_data;
                default:                         r_cfg       <= r_cfg;
            endcase
        end
    end

    crdfe_front u_front (
        .i_in_valid   (i_in_valid),
        .i_q_ready    (q_ready),
        .i_action     (i_action),
        .i_hour       (i_hour),
        .i_minute     (i_minute),
        .i_second     (i_second),
        .i_half_step  (i_half_step),
        .i_ring_count (i_ring_count),
        .o_push       (push),
        .o_job        (push_job)
    );

    crdfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    crdfe_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_job          (q_job),
        .o_q_pop          (q_pop),
        .i_cfg            (r_cfg),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_bus_select     (o_bus_select),
        .o_device_address (o_device_address),
        .o_control_byte   (o_control_byte),
        .o_data_byte0     (o_data_byte0),
        .o_data_byte1     (o_data_byte1),
        .o_data_byte2     (o_data_byte2),
        .o_data_byte3     (o_data_byte3),
        .o_last_frame     (o_last_frame)
    );

endmodule
